FILE: src/ptrs_pkg.sv
// Shared types and constants of the periodic task release scheduler.
// Holds operation, result and status codes, the slot entry layout and the
// controller-to-datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ptrs_pkg;

  // Default number of priority slots.
  localparam int NUM_SLOTS_DEF = 16;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLISION = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NO_TASK   = 2'd3
  } status_t;

  // One slot of the task table.
  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] period;
    logic        running;
    logic [15:0] countdown;
  } slot_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the input beat, clear the slot counter
    logic cmd_rd;     // read the slot addressed by a command
    logic cmd_exe;    // evaluate a command and send its status
    logic tick_step;  // read the next slot, update the previous one
    logic tick_done;  // send the tick done result
  } ptrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;    // the input beat on the port is a tick
    logic sweep_end;  // every slot of the tick has been read
  } ptrs_stat_t;

endpackage

`default_nettype wire

FILE: src/ptrs_ctrl.sv
// Controller of the periodic task release scheduler.
// Sequences one command or one tick sweep at a time. Uses ptrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptrs_ctrl
  import ptrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire ptrs_stat_t stat,
  output ptrs_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CMD_RD  = 5'b00010,
    S_CMD_EXE = 5'b00100,
    S_TICK    = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = stat.is_tick ? S_TICK : S_CMD_RD;
        end
      end
      S_CMD_RD: begin
        cmd.cmd_rd = 1'b1;
        state_nxt  = S_CMD_EXE;
      end
      S_CMD_EXE: begin
        cmd.cmd_exe = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.sweep_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.tick_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: src/ptrs_dp.sv
// Datapath of the periodic task release scheduler.
// Holds the slot table memory, the slot counter and the result register.
// Uses ptrs_pkg and is driven by ptrs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ptrs_dp
  import ptrs_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ptrs_cmd_t   cmd,
  output ptrs_stat_t       stat,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [15:0] in_task_handle,
  input  wire logic [15:0] in_period_ticks,
  input  wire logic [7:0]  in_first_delay,
  output logic             out_strobe,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_fired_slot,
  output logic [15:0]      out_fired_handle,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  // Latched input beat.
  logic [2:0]  op_r;
  logic [7:0]  idx_r;
  logic [15:0] handle_r;
  logic [15:0] period_r;
  logic [7:0]  delay_r;

  logic [CNT_W-1:0] cnt_r;

  // Slot table and its per-entry valid bits; an invalid entry reads as zero.
  slot_ent_t            mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  slot_ent_t         rd_ent_r;
  logic              rd_vld_r;
  slot_ent_t         ent;

  logic              exe_vld_r;
  logic [ADDR_W-1:0] exe_addr_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  slot_ent_t         wr_ent;

  logic idx_ok;
  logic fire;

  logic        out_strobe_r, out_strobe_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_slot_r, out_slot_nxt;
  logic [15:0] out_handle_r, out_handle_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  assign stat.is_tick   = (in_operation == OP_TICK);
  assign stat.sweep_end = (cnt_r == CNT_W'(NUM_SLOTS));

  assign idx_ok = (idx_r < 8'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_operation;
      idx_r    <= in_slot_index;
      handle_r <= in_task_handle;
      period_r <= in_period_ticks;
      delay_r  <= in_first_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.latch) begin
      cnt_r <= '0;
    end else if (cmd.tick_step && !stat.sweep_end) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Read port: the command's slot, or the slot the tick sweep has reached.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r[ADDR_W-1:0];
    if (cmd.cmd_rd) begin
      rd_en   = idx_ok;
      rd_addr = idx_r[ADDR_W-1:0];
    end else if (cmd.tick_step) begin
      rd_en = !stat.sweep_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ent_r <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign ent = rd_vld_r ? rd_ent_r : '0;

  // The slot read in one sweep cycle is updated in the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exe_vld_r <= 1'b0;
    end else begin
      exe_vld_r <= cmd.tick_step && !stat.sweep_end;
    end
  end

  always_ff @(posedge clk) begin
    exe_addr_r <= cnt_r[ADDR_W-1:0];
  end

  assign fire = exe_vld_r && (ent.handle != '0) && ent.running &&
                ((ent.countdown == '0) || (ent.countdown > ent.period));

  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = exe_addr_r;
    wr_ent         = ent;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = KIND_STATUS;
    out_slot_nxt   = idx_r;
    out_handle_nxt = '0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b1;
    if (exe_vld_r) begin
      if ((ent.handle != '0) && ent.running) begin
        wr_en = 1'b1;
        if (fire) begin
          wr_ent.countdown = ent.period;
          out_strobe_nxt   = 1'b1;
          out_kind_nxt     = KIND_FIRE;
          out_slot_nxt     = 8'(exe_addr_r);
          out_handle_nxt   = ent.handle;
          out_last_nxt     = 1'b0;
        end else begin
          wr_ent.countdown = ent.countdown - 16'd1;
        end
      end
    end else if (cmd.tick_done) begin
      out_strobe_nxt = 1'b1;
      out_kind_nxt   = KIND_DONE;
      out_slot_nxt   = '0;
    end else if (cmd.cmd_exe) begin
      out_strobe_nxt = 1'b1;
      wr_addr        = idx_r[ADDR_W-1:0];
      if (!idx_ok) begin
        out_status_nxt = ST_RANGE;
      end else begin
        unique case (op_r)
          OP_CREATE: begin
            if (ent.handle != '0) begin
              out_status_nxt = ST_COLLISION;
            end else begin
              wr_en            = 1'b1;
              wr_ent.handle    = handle_r;
              wr_ent.period    = period_r;
              wr_ent.running   = 1'b1;
              wr_ent.countdown = {8'd0, delay_r};
            end
          end
          OP_DELETE, OP_SUSPEND, OP_RESUME: begin
            if (ent.handle == '0) begin
              out_status_nxt = ST_NO_TASK;
            end else begin
              wr_en = 1'b1;
              if (op_r == OP_DELETE) begin
                wr_ent.handle  = '0;
                wr_ent.period  = '0;
                wr_ent.running = 1'b0;
              end else begin
                wr_ent.running = (op_r == OP_RESUME);
              end
            end
          end
          default: begin
            out_status_nxt = ST_RANGE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_kind         = out_kind_r;
  assign out_fired_slot   = out_slot_r;
  assign out_fired_handle = out_handle_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

FILE: src/periodic_task_release_scheduler_unit.sv
// Top level of the periodic task release scheduler.
// Joins the controller ptrs_ctrl and the datapath ptrs_dp; uses ptrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A beat is taken at a rising edge where start is high and busy is low.
// Create, delete, suspend and resume, and any unknown operation, answer
// with one status beat after the read and evaluate states; the block is
// busy in those states and takes the next beat in the cycle the status
// shows. A tick walks the slot table through the single read port of the
// slot memory, one slot per cycle, with the update of each slot overlapped
// with the read of the next; busy stays high through the sweep and the
// done state. Fire beats come out in ascending slot order, one per cycle
// at most, and the done beat (out_last high) closes the tick; the next
// beat can be taken in the cycle it shows. Every result is on the out_ ports
// for exactly one cycle, marked by out_strobe; the receiver cannot stall
// them, so it must take each beat as it comes. No clearing pass is needed
// after reset: per-slot valid bits make every slot read as free and zero.
module periodic_task_release_scheduler_unit
  import ptrs_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [15:0] in_task_handle,
  input  wire logic [15:0] in_period_ticks,
  input  wire logic [7:0]  in_first_delay,
  output logic             out_strobe,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_fired_slot,
  output logic [15:0]      out_fired_handle,
  output logic [1:0]       out_status,
  output logic             out_last
);

  ptrs_cmd_t  cmd;
  ptrs_stat_t stat;

  // The controller decides what happens in each cycle.
  ptrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath owns the slot table and the registered result.
  ptrs_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_task_handle   (in_task_handle),
    .in_period_ticks  (in_period_ticks),
    .in_first_delay   (in_first_delay),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_fired_slot   (out_fired_slot),
    .out_fired_handle (out_fired_handle),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

FILE: src/ptrs_checker.sv
// Port-level checks of the periodic task release scheduler.
// Uses ptrs_pkg and binds to periodic_task_release_scheduler_unit.
`timescale 1ns / 1ps
`default_nettype none

module ptrs_checker
  import ptrs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic [1:0]  out_kind,
  input wire logic [15:0] out_fired_handle,
  input wire logic        out_last
);

  // Taking a beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a beat");

  // A command status is a single, final beat with no handle.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_STATUS) |-> out_last && (out_fired_handle == '0))
    else $error("command status beat malformed");

  // A fire beat names an occupied slot and never closes the item.
  a_fire_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_FIRE) |-> !out_last && (out_fired_handle != '0))
    else $error("fire beat malformed");

  // Only the tick done beat and command status beats close an item.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KIND_DONE) |-> out_last)
    else $error("tick done beat without last");

  // The final beat of one item is never followed at once by another beat.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("result beat right after a final beat");

endmodule

bind periodic_task_release_scheduler_unit ptrs_checker u_ptrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_kind         (out_kind),
  .out_fired_handle (out_fired_handle),
  .out_last         (out_last)
);

`default_nettype wire

FILE: test/ptrs_release_checker.sv
// Checker for the periodic task release scheduler: watches the command and
// result channels, keeps its own copy of the slot table and compares each beat.
// Depends on ptrs_pkg for the operation, kind and status codes.
`timescale 1ns / 1ps

module ptrs_release_checker
  import ptrs_pkg::*;
#(
  parameter int NSLOT = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_slot_index,
  input  logic [15:0] in_task_handle,
  input  logic [15:0] in_period_ticks,
  input  logic [7:0]  in_first_delay,
  input  logic        out_strobe,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_fired_slot,
  input  logic [15:0] out_fired_handle,
  input  logic [1:0]  out_status,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          n_tick,
  output int          n_cmd,
  output int          n_fire
);

  typedef struct {
    kind_t       kind;
    logic [7:0]  slot;
    logic [15:0] handle;
    status_t     status;
    logic        last;
  } release_beat_t;

  logic [15:0]   tbl_handle [NSLOT];
  logic [15:0]   tbl_period [NSLOT];
  logic          tbl_run    [NSLOT];
  logic [15:0]   tbl_count  [NSLOT];
  release_beat_t due_beats[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    n_tick     = 0;
    n_cmd      = 0;
    n_fire     = 0;
  end

  // One pass over the table: fire beats in slot order, then the done beat.
  function automatic void sweep_slots();
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_handle[i] != 16'd0 && tbl_run[i]) begin
        if (tbl_count[i] == 16'd0 || tbl_count[i] > tbl_period[i]) begin
          due_beats.push_back('{KIND_FIRE, 8'(i), tbl_handle[i], ST_OK, 1'b0});
          tbl_count[i] = tbl_period[i];
        end else begin
          tbl_count[i] = tbl_count[i] - 16'd1;
        end
      end
    end
    due_beats.push_back('{KIND_DONE, 8'd0, 16'd0, ST_OK, 1'b1});
  endfunction

  function automatic status_t apply_command(logic [2:0] op, logic [7:0] idx,
                                            logic [15:0] hnd, logic [15:0] per,
                                            logic [7:0] dly);
    if (op > OP_RESUME || idx >= NSLOT) return ST_RANGE;
    if (op == OP_CREATE) begin
      if (tbl_handle[idx] != 16'd0) return ST_COLLISION;
      tbl_handle[idx] = hnd;
      tbl_period[idx] = per;
      tbl_run[idx]    = 1'b1;
      tbl_count[idx]  = {8'd0, dly};
      return ST_OK;
    end
    if (tbl_handle[idx] == 16'd0) return ST_NO_TASK;
    case (op)
      OP_DELETE: begin
        tbl_handle[idx] = 16'd0;
        tbl_period[idx] = 16'd0;
        tbl_run[idx]    = 1'b0;
      end
      OP_SUSPEND: tbl_run[idx] = 1'b0;
      default:    tbl_run[idx] = 1'b1;
    endcase
    return ST_OK;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    release_beat_t want;
    status_t       st;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        tbl_handle[i] = 16'd0;
        tbl_period[i] = 16'd0;
        tbl_run[i]    = 1'b0;
        tbl_count[i]  = 16'd0;
      end
      due_beats.delete();
    end else begin
      if ($isunknown(busy) || $isunknown(out_strobe)) begin
        $error("handshake: expected known busy and out_strobe, got %b %b", busy, out_strobe);
        fail_count++;
      end
      if (start && !busy) begin
        if (in_operation == OP_TICK) begin
          n_tick++;
          sweep_slots();
        end else begin
          n_cmd++;
          st = apply_command(in_operation, in_slot_index, in_task_handle,
                             in_period_ticks, in_first_delay);
          due_beats.push_back('{KIND_STATUS, in_slot_index, 16'd0, st, 1'b1});
        end
      end
      if (out_strobe) begin
        if (due_beats.size() == 0) begin
          $error("result beat: expected none, got kind %0d slot %0d", out_kind,
                 out_fired_slot);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          if (want.kind == KIND_FIRE) n_fire++;
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("fired_slot", 16'(want.slot), 16'(out_fired_slot));
          check_field("fired_handle", want.handle, out_fired_handle);
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
    pending <= due_beats.size();
  end

endmodule

FILE: test/tb.sv
// Top of the testbench for periodic_task_release_scheduler_unit: clock,
// reset, command stimulus and verdict. Uses ptrs_pkg and ptrs_release_checker.
`timescale 1ns / 1ps

module tb;
  import ptrs_pkg::*;

  localparam int N_RANDOM = 220;
  // The tail of the random part runs with no idle cycles at all.
  localparam int N_TAIL   = 40;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [2:0]  in_operation    = 3'd0;
  logic [7:0]  in_slot_index   = 8'd0;
  logic [15:0] in_task_handle  = 16'd0;
  logic [15:0] in_period_ticks = 16'd0;
  logic [7:0]  in_first_delay  = 8'd0;
  logic        busy;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [7:0]  out_fired_slot;
  logic [15:0] out_fired_handle;
  logic [1:0]  out_status;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          n_tick;
  int          n_cmd;
  int          n_fire;

  periodic_task_release_scheduler_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_task_handle   (in_task_handle),
    .in_period_ticks  (in_period_ticks),
    .in_first_delay   (in_first_delay),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_fired_slot   (out_fired_slot),
    .out_fired_handle (out_fired_handle),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  // The checker sits beside the block, sees exactly what the block sees and
  // hands back its failure count and the number of beats still owed.
  ptrs_release_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_task_handle   (in_task_handle),
    .in_period_ticks  (in_period_ticks),
    .in_first_delay   (in_first_delay),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_fired_slot   (out_fired_slot),
    .out_fired_handle (out_fired_handle),
    .out_status       (out_status),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending),
    .n_tick           (n_tick),
    .n_cmd            (n_cmd),
    .n_fire           (n_fire)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Present one command beat and hold it until the block takes it. The
  // caller is always sitting on a rising edge here, so busy as read after
  // the next edge is the value that decided acceptance at that edge. Start
  // is left high, so back-to-back beats never lower and raise it in one step.
  task automatic send_beat(logic [2:0] op, logic [7:0] idx, logic [15:0] hnd,
                           logic [15:0] per, logic [7:0] dly);
    start           <= 1'b1;
    in_operation    <= op;
    in_slot_index   <= idx;
    in_task_handle  <= hnd;
    in_period_ticks <= per;
    in_first_delay  <= dly;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle the sender. The payload carries junk meanwhile, which the block
  // must ignore while start is low.
  task automatic hold_off(int cycles);
    start           <= 1'b0;
    in_operation    <= 3'($urandom);
    in_slot_index   <= 8'($urandom);
    in_task_handle  <= 16'($urandom);
    in_period_ticks <= 16'($urandom);
    in_first_delay  <= 8'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every owed result beat has come back. The pending
  // count is registered, so the task waits past the next edge before trusting it.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
  endtask

  initial begin : stimulus
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [15:0] hnd;
    logic [15:0] per;
    logic [7:0]  dly;
    int          pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table ticks to a lone done beat.
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    // Delete, suspend and resume on a free slot all answer no task.
    send_beat(OP_DELETE, 8'd3, 16'd0, 16'd0, 8'd0);
    send_beat(OP_SUSPEND, 8'd3, 16'd0, 16'd0, 8'd0);
    maybe_idle();
    send_beat(OP_RESUME, 8'd3, 16'd0, 16'd0, 8'd0);
    // All-ones create in the highest-priority slot, then a collision on it.
    send_beat(OP_CREATE, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(OP_CREATE, 8'd0, 16'h0001, 16'd5, 8'd1);
    // Last slot with period and delay zero fires on every tick.
    send_beat(OP_CREATE, 8'(NUM_SLOTS_DEF - 1), 16'h0001, 16'd0, 8'd0);
    // First index past the table and the largest index are out of range.
    send_beat(OP_CREATE, 8'(NUM_SLOTS_DEF), 16'h00AA, 16'd1, 8'd1);
    send_beat(OP_CREATE, 8'hFF, 16'h00AA, 16'd1, 8'd1);
    // A zero handle writes the slot's timing but leaves the slot free.
    send_beat(OP_CREATE, 8'd5, 16'h0000, 16'd3, 8'd2);
    // A countdown above its period fires on the first tick.
    send_beat(OP_CREATE, 8'd7, 16'h1234, 16'd2, 8'd200);
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    // A suspended slot freezes and picks up again after resume.
    send_beat(OP_SUSPEND, 8'(NUM_SLOTS_DEF - 1), 16'd0, 16'd0, 8'd0);
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    send_beat(OP_RESUME, 8'(NUM_SLOTS_DEF - 1), 16'd0, 16'd0, 8'd0);
    maybe_idle();
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    // Delete twice: the second finds the slot free.
    send_beat(OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd0);
    send_beat(OP_DELETE, 8'd0, 16'd0, 16'd0, 8'd0);
    // Unknown operation codes answer out of range and echo the index.
    send_beat(3'd5, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(3'd6, 8'd0, 16'd0, 16'd0, 8'd0);
    send_beat(3'd7, 8'd9, 16'h5A5A, 16'hA5A5, 8'h3C);
    // Out-of-range index on the other slot commands.
    send_beat(OP_SUSPEND, 8'd200, 16'd0, 16'd0, 8'd0);
    send_beat(OP_RESUME, 8'd128, 16'd0, 16'd0, 8'd0);
    send_beat(OP_TICK, 8'd0, 16'd0, 16'd0, 8'd0);

    // Let the table settle completely before the random part.
    drain_results();

    // Random part. Indices mostly land in the table and periods are mostly
    // short so that slots fill, collide, fire and get churned by deletes.
    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_TICK;
      else if (pick < 63) op = OP_CREATE;
      else if (pick < 73) op = OP_DELETE;
      else if (pick < 83) op = OP_SUSPEND;
      else if (pick < 94) op = OP_RESUME;
      else                op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(NUM_SLOTS_DEF, 255));
      else                           idx = 8'($urandom_range(0, NUM_SLOTS_DEF - 1));
      case ($urandom_range(0, 9))
        0:       hnd = 16'd0;
        1:       hnd = 16'hFFFF;
        default: hnd = 16'($urandom);
      endcase
      per = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      dly = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      send_beat(op, idx, hnd, per, dly);

      // Halfway through, the sender waits out every owed result once more.
      if (k == N_RANDOM / 2) drain_results();
      else if (k < N_RANDOM - N_TAIL) maybe_idle();
    end

    drain_results();
    // A few more cycles catch any stray beat the block might still emit.
    repeat (10) @(posedge clk);

    $display("summary: %0d ticks and %0d slot commands sent, %0d task fires checked,",
             n_tick, n_cmd, n_fire);
    $display("summary: covering collisions, free slots, suspend/resume and bad indices");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
